// File: design/epg_pkg.sv
// Shared types, constants and tables for the epicycloid point generator.
package epg_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int CW = 34;   // CORDIC datapath width
   localparam int IDXW = 5;  // stage index width

   localparam logic [29:0] TURN_PER_RAD = 30'h28BE60DB;
   localparam logic signed [CW-1:0] CORDIC_START = 34'sh26DD3B6A;
   localparam logic [23:0] RATIO_MAX = 24'hFFFFFF;
   localparam logic [23:0] RATIO_RESET = 24'd294912;

   localparam logic [2:0] REG_BIG_RADIUS   = 3'd0;
   localparam logic [2:0] REG_SMALL_RADIUS = 3'd1;
   localparam logic [2:0] REG_ANGLE_STEP   = 3'd2;
   localparam logic [2:0] REG_ANGLE_LIMIT  = 3'd3;
   localparam logic [2:0] REG_OFFSET_X     = 3'd4;
   localparam logic [2:0] REG_OFFSET_Y     = 3'd5;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic valid;
      logic tag;   // 0: angle t, 1: angle kt
      logic neg;   // result must be negated (folded half turn)
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

endpackage

// File: design/epg_cell.sv
// One CORDIC rotation cell of the chain.
module epg_cell (
   input  logic clock,
   input  logic reset,
   input  logic [epg_pkg::IDXW-1:0] stage_idx,
   input  epg_pkg::cordic_type cell_in,
   output epg_pkg::cordic_type cell_out
);
   epg_pkg::cordic_type cell_ff, rot_in;
   logic signed [epg_pkg::CW-1:0] dx, dy, da;

   always_comb begin
      dx = cell_in.y >>> stage_idx;
      dy = cell_in.x >>> stage_idx;
      da = epg_pkg::CW'(signed'({1'b0, epg_pkg::ATAN_TURNS[stage_idx]}));
      rot_in = cell_in;
      if (cell_in.z >= 0) begin
         rot_in.x = cell_in.x - dx;
         rot_in.y = cell_in.y + dy;
         rot_in.z = cell_in.z - da;
      end else begin
         rot_in.x = cell_in.x + dx;
         rot_in.y = cell_in.y - dy;
         rot_in.z = cell_in.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= rot_in.valid;
      end
      cell_ff.tag <= rot_in.tag;
      cell_ff.neg <= rot_in.neg;
      cell_ff.x   <= rot_in.x;
      cell_ff.y   <= rot_in.y;
      cell_ff.z   <= rot_in.z;
   end

   assign cell_out = cell_ff;
endmodule

// File: design/epg_div.sv
// Bit-serial restoring divider for the ratio (R+r)*2^16 / r, saturated to 24 bits.
module epg_div (
   input  logic clock,
   input  logic reset,
   input  epg_pkg::div_ctl_type ctl_in,
   output logic div_busy,
   input  logic [16:0] sum_r,
   input  logic [15:0] small_r,
   output logic [23:0] ratio
);
   logic [32:0] num_ff;
   logic [15:0] rem_ff;
   logic [23:0] quo_ff;
   logic [15:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [16:0] rem_sh;
   logic        sat;

   assign sat    = {7'd0, sum_r} >= {small_r, 8'd0};
   assign rem_sh = {rem_ff, num_ff[32]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         quo_ff  <= epg_pkg::RATIO_RESET;
         cnt_ff  <= '0;
      end else if (ctl_in.start) begin
         if (sat) begin
            quo_ff  <= epg_pkg::RATIO_MAX;
            busy_ff <= 1'b0;
         end else begin
            busy_ff <= 1'b1;
            num_ff  <= {sum_r, 16'd0};
            rem_ff  <= '0;
            div_ff  <= small_r;
            cnt_ff  <= 6'd33;
         end
      end else if (busy_ff) begin
         num_ff <= {num_ff[31:0], 1'b0};
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_ff <= 16'(rem_sh - {1'b0, div_ff});
            quo_ff <= {quo_ff[22:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[15:0];
            quo_ff <= {quo_ff[22:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_ff <= 1'b0;
      end
   end

   assign div_busy = busy_ff || ctl_in.start;
   assign ratio    = quo_ff;
endmodule

// File: design/epicycloid_point_generator_unit.sv
// A point passes S_MUL1, S_MUL2, S_FEED1 and S_FEED2, the CORDIC cell chain, S_MULC and S_FIN to rsp_valid.
// A new word is accepted only once the previous one is through, since req_ready is high only in S_IDLE.
// A restart runs the bit-serial ratio divider in S_DIV (the divider is bypassed if the ratio saturates).
// A word that gives no point (finished) is consumed in S_IDLE; a stalled rsp word holds the next point.
// Synchronous active-high reset loads register defaults, angle 0 and the reset ratio.
module epicycloid_point_generator_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_restart,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_point_x,
   output logic signed [15:0] rsp_point_y,
   output logic rsp_final_point,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [21:0] csr_wdata
);
   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_MUL1, S_MUL2, S_FEED1, S_FEED2, S_WAIT, S_MULC, S_FIN
   } state_type;

   state_type state_ff;
   logic [15:0] big_r_ff, small_r_ff, step_ff;
   logic [21:0] limit_ff;
   logic signed [15:0] offx_ff, offy_ff;
   logic [22:0] angle_ff, angle_in;
   logic        finished_ff;
   logic [46:0] kprod_ff;
   logic [31:0] turns1_ff, turns2_ff;
   logic signed [33:0] c1_ff, s1_ff, c2_ff, s2_ff;
   logic signed [51:0] px1_ff, px2_ff, py1_ff, py2_ff;
   logic rsp_valid_ff;
   logic signed [15:0] rsp_x_ff, rsp_y_ff;
   logic rsp_final_ff;

   logic [23:0] ratio;
   logic div_busy;
   epg_pkg::div_ctl_type div_ctl;
   logic [16:0] sum_r;
   logic req_acc;
   logic [52:0] t1_prod;
   logic [60:0] t2_prod;
   logic [31:0] feed_turns, feed_t;
   logic feed_neg;
   logic signed [33:0] tail_x, tail_y;
   logic signed [15:0] cx, cy;
   logic final_in;

   epg_pkg::cordic_type chain [epg_pkg::CORDIC_STAGES+1];

   assign sum_r    = {1'b0, big_r_ff} + {1'b0, small_r_ff};
   assign req_ready = (state_ff == S_IDLE);
   assign req_acc  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign div_ctl.start = req_acc && req_restart;

   epg_div u_div (
      .clock(clock), .reset(reset), .ctl_in(div_ctl), .div_busy(div_busy),
      .sum_r(sum_r), .small_r(small_r_ff), .ratio(ratio)
   );

   // fold quadrants 1 and 2 by half a turn
   assign feed_turns = (state_ff == S_FEED1) ? turns1_ff : turns2_ff;
   assign feed_neg   = (feed_turns[31:30] == 2'd1) || (feed_turns[31:30] == 2'd2);
   assign feed_t     = feed_neg ? feed_turns - 32'h80000000 : feed_turns;

   always_comb begin
      chain[0].valid = (state_ff == S_FEED1) || (state_ff == S_FEED2);
      chain[0].tag   = (state_ff == S_FEED2);
      chain[0].neg   = feed_neg;
      chain[0].x     = epg_pkg::CORDIC_START;
      chain[0].y     = '0;
      chain[0].z     = 34'(signed'(feed_t));
   end

   for (genvar g = 0; g < epg_pkg::CORDIC_STAGES; g++) begin : g_cell
      epg_cell u_cell (
         .clock(clock), .reset(reset),
         .stage_idx(epg_pkg::IDXW'(g)),
         .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   assign tail_x = chain[epg_pkg::CORDIC_STAGES].neg ?
                   -chain[epg_pkg::CORDIC_STAGES].x : chain[epg_pkg::CORDIC_STAGES].x;
   assign tail_y = chain[epg_pkg::CORDIC_STAGES].neg ?
                   -chain[epg_pkg::CORDIC_STAGES].y : chain[epg_pkg::CORDIC_STAGES].y;

   assign t1_prod = {30'd0, angle_ff} * {23'd0, epg_pkg::TURN_PER_RAD};
   assign t2_prod = {30'd0, kprod_ff[46:16]} * {31'd0, epg_pkg::TURN_PER_RAD};

   function automatic logic signed [15:0] coord(input logic signed [51:0] p1,
                                                input logic signed [51:0] p2,
                                                input logic signed [15:0] off);
      logic signed [53:0] v;
      logic signed [19:0] s;
      v = 54'(p1) - 54'(p2) + (54'(off) <<< 34) + (54'sd1 <<< 33);
      s = 20'(v >>> 34);
      if (s > 20'sd32767) coord = 16'sh7FFF;
      else if (s < -20'sd32768) coord = 16'sh8000;
      else coord = s[15:0];
   endfunction

   assign cx = coord(px1_ff, px2_ff, offx_ff);
   assign cy = coord(py1_ff, py2_ff, offy_ff);
   assign angle_in = angle_ff + {7'd0, step_ff};
   assign final_in = angle_in > {1'b0, limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         big_r_ff     <= 16'd17920;
         small_r_ff   <= 16'd5120;
         step_ff      <= 16'd655;
         limit_ff     <= 22'd2058874;
         offx_ff      <= 16'sd4800;
         offy_ff      <= 16'sd4800;
         angle_ff     <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               epg_pkg::REG_BIG_RADIUS:   big_r_ff   <= csr_wdata[15:0];
               epg_pkg::REG_SMALL_RADIUS: small_r_ff <= csr_wdata[15:0];
               epg_pkg::REG_ANGLE_STEP:   step_ff    <= csr_wdata[15:0];
               epg_pkg::REG_ANGLE_LIMIT:  limit_ff   <= csr_wdata;
               epg_pkg::REG_OFFSET_X:     offx_ff    <= csr_wdata[15:0];
               epg_pkg::REG_OFFSET_Y:     offy_ff    <= csr_wdata[15:0];
               default: ;
            endcase
         end
         // the last state reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_FIN) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  if (req_restart) begin
                     angle_ff    <= '0;
                     finished_ff <= 1'b0;
                     state_ff    <= S_DIV;
                  end else if (finished_ff || angle_ff > {1'b0, limit_ff}) begin
                     finished_ff <= 1'b1;
                  end else begin
                     state_ff <= S_MUL1;
                  end
               end
            end
            S_DIV: if (!div_busy) state_ff <= S_IDLE;
            S_MUL1: begin
               kprod_ff  <= 47'(ratio * angle_ff);
               turns1_ff <= t1_prod[47:16];
               state_ff  <= S_MUL2;
            end
            S_MUL2: begin
               turns2_ff <= t2_prod[47:16];
               state_ff  <= S_FEED1;
            end
            S_FEED1: state_ff <= S_FEED2;
            S_FEED2: state_ff <= S_WAIT;
            S_WAIT: begin
               if (chain[epg_pkg::CORDIC_STAGES].valid) begin
                  if (!chain[epg_pkg::CORDIC_STAGES].tag) begin
                     c1_ff <= tail_x;
                     s1_ff <= tail_y;
                  end else begin
                     c2_ff    <= tail_x;
                     s2_ff    <= tail_y;
                     state_ff <= S_MULC;
                  end
               end
            end
            S_MULC: begin
               px1_ff   <= 52'(signed'({1'b0, sum_r}) * c1_ff);
               px2_ff   <= 52'(signed'({1'b0, small_r_ff}) * c2_ff);
               py1_ff   <= 52'(signed'({1'b0, sum_r}) * s1_ff);
               py2_ff   <= 52'(signed'({1'b0, small_r_ff}) * s2_ff);
               state_ff <= S_FIN;
            end
            S_FIN: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= cx;
                  rsp_y_ff     <= cy;
                  rsp_final_ff <= final_in;
                  angle_ff     <= angle_in;
                  if (final_in) finished_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_final_point = rsp_final_ff;
endmodule

// File: design/epg_check.sv
// Port-level checker for the epicycloid point generator, bound to the top level.
module epg_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_restart,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart |=> !req_ready)
      else $error("restart did not start the ratio divider");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp word appeared without a point computation");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind epicycloid_point_generator_unit epg_check u_epg_check (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_restart(req_restart), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
);
